>>> rtl/dasp_pkg.sv
// shared types and constants for the dial angle to servo pulse block
// no dependencies; compiled first
package dasp_pkg;

  localparam int DIAL_W     = 17;
  localparam int ANGLE_W    = 16;
  localparam int PULSE_W    = 16;
  localparam int TRIM_W     = 17;
  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 32;
  localparam int REG_IDX_W  = 3;

  typedef logic signed [DIAL_W-1:0] dial_t;
  typedef logic [ANGLE_W-1:0]       angle_t;
  typedef logic [PULSE_W-1:0]       pulse_t;
  typedef logic signed [TRIM_W-1:0] trim_t;

  // register indexes, byte address is 4 * index
  localparam logic [REG_IDX_W-1:0] REG_MIN_PULSE = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_MAX_PULSE = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_TRAVEL    = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_GEAR      = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_TRIM      = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_REVERSED  = 3'd5;

  localparam pulse_t RST_MIN_PULSE = 16'd1000;
  localparam pulse_t RST_MAX_PULSE = 16'd2000;
  localparam angle_t RST_TRAVEL    = 16'd18000;
  localparam logic [15:0] RST_GEAR = 16'd256;

endpackage

>>> rtl/dasp_if.sv
// valid/ready channel interfaces for dial angles in and servo pulses out
// depends on dasp_pkg
interface dasp_in_if import dasp_pkg::*; ();
  logic  valid;
  logic  ready;
  dial_t dial_centideg;
  logic  angle_unusable;

  modport source (output valid, output dial_centideg, output angle_unusable, input ready);
  modport sink   (input valid, input dial_centideg, input angle_unusable, output ready);
endinterface

interface dasp_out_if import dasp_pkg::*; ();
  logic   valid;
  logic   ready;
  pulse_t pulse_us;
  angle_t shaft_centideg;
  logic   calibration_ok;

  modport source (output valid, output pulse_us, output shaft_centideg,
                  output calibration_ok, input ready);
  modport sink   (input valid, input pulse_us, input shaft_centideg,
                  input calibration_ok, output ready);
endinterface

>>> rtl/dasp_div.sv
// pipelined restoring divider, one quotient bit per register stage
// depends on dasp_pkg; divisor must stay constant while items are in flight
module dasp_div import dasp_pkg::*; #(
  parameter int NUM_W  = 34,
  parameter int DEN_W  = 17,
  parameter int QUO_W  = 16,
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_vld,
  input  logic [NUM_W-1:0]  num,
  input  logic [DEN_W-1:0]  den,
  input  logic [SIDE_W-1:0] side_in,
  output logic              out_vld,
  output logic [QUO_W-1:0]  quo,
  output logic [SIDE_W-1:0] side_out
);

  // numerator bits above the quotient must form a value below den
  localparam int HI_W = NUM_W - QUO_W;

  logic [DEN_W-1:0]  rem  [QUO_W];
  logic [QUO_W-1:0]  low  [QUO_W];
  logic [SIDE_W-1:0] side [QUO_W];
  logic [QUO_W-1:0]  vld;

  logic [HI_W+DEN_W-1:0] hi_ext;
  logic [DEN_W:0]        den_ext;

  assign hi_ext  = {{DEN_W{1'b0}}, num[NUM_W-1:QUO_W]};
  assign den_ext = {1'b0, den};

  for (genvar k = 0; k < QUO_W; k++) begin : g_stage
    logic [DEN_W-1:0]  rem_cur;
    logic [QUO_W-1:0]  low_cur;
    logic [SIDE_W-1:0] side_cur;
    logic              vld_cur;
    logic [DEN_W:0]    trial;
    logic [DEN_W:0]    diff;
    logic              ge;

    if (k == 0) begin : g_first
      assign rem_cur  = hi_ext[DEN_W-1:0];
      assign low_cur  = num[QUO_W-1:0];
      assign side_cur = side_in;
      assign vld_cur  = in_vld;
    end else begin : g_next
      assign rem_cur  = rem[k-1];
      assign low_cur  = low[k-1];
      assign side_cur = side[k-1];
      assign vld_cur  = vld[k-1];
    end

    // shift in the next numerator bit, subtract when it fits
    assign trial = {rem_cur, low_cur[QUO_W-1]};
    assign ge    = (trial >= den_ext);
    assign diff  = trial - den_ext;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (en) begin
        vld[k] <= vld_cur;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k]  <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        low[k]  <= {low_cur[QUO_W-2:0], ge};
        side[k] <= side_cur;
      end
    end
  end

  assign out_vld  = vld[QUO_W-1];
  assign quo      = low[QUO_W-1];
  assign side_out = side[QUO_W-1];

endmodule

>>> rtl/dial_angle_to_servo_pulse.sv
// dial angle to servo pulse: one register stage per quotient bit in the two dividers
// plus six plain stages
// throughput one transaction per cycle; the whole pipe holds while the output waits
// rst (synchronous) empties the pipe and loads the calibration registers with their
// defaults: 1000/2000 us, 18000 centidegree travel, unity gear, zero trim, not reversed
// depends on dasp_pkg, dasp_if and dasp_div
module dial_angle_to_servo_pulse import dasp_pkg::*; #(
  parameter int GEAR_FRAC_BITS = 8
) (
  input  logic                  clk,
  input  logic                  rst,
  // register port
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready,
  // channels
  dasp_in_if.sink               dial,
  dasp_out_if.source            pulse
);

  // magnitude width of the gear division numerator dial * 2^(F+1) + gear
  localparam int NB    = GEAR_FRAC_BITS + 19;
  // shaft sum width: trim plus signed quotient with headroom
  localparam int SUM_W = NB + 2;
  // pulse division numerator 2 * pos * span + travel
  localparam int N2_W  = 2 * ANGLE_W + 2;

  // ---------------------------------------------------------------------------
  // calibration registers
  // ---------------------------------------------------------------------------
  pulse_t      min_pulse_us;
  pulse_t      max_pulse_us;
  angle_t      travel_centideg;
  logic [15:0] gear_ratio_q8;
  trim_t       trim_centideg;
  logic        reversed;

  logic [REG_IDX_W-1:0] reg_idx;
  logic                 cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = paddr[CFG_ADDR_W-1:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_pulse_us    <= RST_MIN_PULSE;
      max_pulse_us    <= RST_MAX_PULSE;
      travel_centideg <= RST_TRAVEL;
      gear_ratio_q8   <= RST_GEAR;
      trim_centideg   <= '0;
      reversed        <= 1'b0;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_MIN_PULSE: min_pulse_us    <= pwdata[PULSE_W-1:0];
        REG_MAX_PULSE: max_pulse_us    <= pwdata[PULSE_W-1:0];
        REG_TRAVEL:    travel_centideg <= pwdata[ANGLE_W-1:0];
        REG_GEAR:      gear_ratio_q8   <= pwdata[15:0];
        REG_TRIM:      trim_centideg   <= pwdata[TRIM_W-1:0];
        REG_REVERSED:  reversed        <= pwdata[0];
        default: begin
          // addresses past the register list are ignored
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_MIN_PULSE: prdata = {{(CFG_DATA_W-PULSE_W){1'b0}}, min_pulse_us};
      REG_MAX_PULSE: prdata = {{(CFG_DATA_W-PULSE_W){1'b0}}, max_pulse_us};
      REG_TRAVEL:    prdata = {{(CFG_DATA_W-ANGLE_W){1'b0}}, travel_centideg};
      REG_GEAR:      prdata = {{(CFG_DATA_W-16){1'b0}}, gear_ratio_q8};
      REG_TRIM:      prdata = {{(CFG_DATA_W-TRIM_W){1'b0}}, trim_centideg};
      REG_REVERSED:  prdata = {{(CFG_DATA_W-1){1'b0}}, reversed};
      default:       prdata = '0;
    endcase
  end

  // the user must keep calibration written only while the pipe is empty (not enforced
  // by the block itself), so every stage can read the registers directly
  logic   cal_ok;
  pulse_t span;

  assign cal_ok = (max_pulse_us > min_pulse_us) && (travel_centideg != '0) &&
                  (gear_ratio_q8 != '0);
  assign span   = max_pulse_us - min_pulse_us;

  // ---------------------------------------------------------------------------
  // pipe control: every stage moves together when the output register is free
  // or being emptied; the input stage also fills while it is empty
  // ---------------------------------------------------------------------------
  logic en;
  logic out_vld;

  assign en = !out_vld || pulse.ready;

  // ---------------------------------------------------------------------------
  // stage a: capture the transaction
  // ---------------------------------------------------------------------------
  logic  a_vld;
  dial_t a_dial;
  logic  a_unusable;

  assign dial.ready = en || !a_vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
    end else if (dial.ready) begin
      a_vld <= dial.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (dial.ready) begin
      a_dial     <= dial.dial_centideg;
      a_unusable <= dial.angle_unusable;
    end
  end

  // numerator dial * 2^(F+1) + gear, signed; floor division of a negative
  // value uses floor(n/d) = ~floor(~n/d) on the one's complement
  logic [NB:0]   n1;
  logic          n1_neg;
  logic [NB:0]   n1_mag;
  logic [16:0]   den1;

  assign n1     = ({{(NB+1-DIAL_W){a_dial[DIAL_W-1]}}, a_dial} << (GEAR_FRAC_BITS + 1)) +
                  {{(NB+1-16){1'b0}}, gear_ratio_q8};
  assign n1_neg = n1[NB];
  assign n1_mag = n1_neg ? {1'b0, ~n1[NB-1:0]} : {1'b0, n1[NB-1:0]};
  assign den1   = {gear_ratio_q8, 1'b0};

  // ---------------------------------------------------------------------------
  // gear division, one quotient bit per stage
  // ---------------------------------------------------------------------------
  logic          d1_vld;
  logic [NB-1:0] d1_quo;
  logic [1:0]    d1_side;

  dasp_div #(
    .NUM_W  (NB + 1),
    .DEN_W  (17),
    .QUO_W  (NB),
    .SIDE_W (2)
  ) u_gear_div (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_vld   (a_vld),
    .num      (n1_mag),
    .den      (den1),
    .side_in  ({a_unusable, n1_neg}),
    .out_vld  (d1_vld),
    .quo      (d1_quo),
    .side_out (d1_side)
  );

  // ---------------------------------------------------------------------------
  // stage b: add trim and clamp to 0..travel
  // ---------------------------------------------------------------------------
  logic [NB:0]      q_s;
  logic [SUM_W-1:0] shaft_sum;
  logic             sum_neg;
  logic             sum_over;
  angle_t           shaft_clamped;

  assign q_s       = d1_side[0] ? ~{1'b0, d1_quo} : {1'b0, d1_quo};
  // unusable angle: trim alone
  assign shaft_sum = {{(SUM_W-TRIM_W){trim_centideg[TRIM_W-1]}}, trim_centideg} +
                     (d1_side[1] ? {SUM_W{1'b0}} : {q_s[NB], q_s});
  assign sum_neg   = shaft_sum[SUM_W-1];
  assign sum_over  = shaft_sum > {{(SUM_W-ANGLE_W){1'b0}}, travel_centideg};

  always_comb begin
    if (sum_neg) begin
      shaft_clamped = '0;
    end else if (sum_over) begin
      shaft_clamped = travel_centideg;
    end else begin
      shaft_clamped = shaft_sum[ANGLE_W-1:0];
    end
  end

  logic   b_vld;
  angle_t b_shaft;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_vld <= 1'b0;
    end else if (en) begin
      b_vld <= d1_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_shaft <= shaft_clamped;
    end
  end

  // ---------------------------------------------------------------------------
  // stage c: mirror within travel when reversed
  // ---------------------------------------------------------------------------
  logic   c_vld;
  angle_t c_shaft;
  angle_t c_pos;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_vld <= 1'b0;
    end else if (en) begin
      c_vld <= b_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_shaft <= b_shaft;
      c_pos   <= reversed ? (travel_centideg - b_shaft) : b_shaft;
    end
  end

  // ---------------------------------------------------------------------------
  // stage d: pos * span, 16 x 16
  // ---------------------------------------------------------------------------
  logic                 d_vld;
  angle_t               d_shaft;
  logic [2*ANGLE_W-1:0] d_prod;

  always_ff @(posedge clk) begin
    if (rst) begin
      d_vld <= 1'b0;
    end else if (en) begin
      d_vld <= c_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_shaft <= c_shaft;
      d_prod  <= {{ANGLE_W{1'b0}}, c_pos} * {{(2*ANGLE_W-PULSE_W){1'b0}}, span};
    end
  end

  // ---------------------------------------------------------------------------
  // stage e: rounding numerator 2 * prod + travel
  // ---------------------------------------------------------------------------
  logic            e_vld;
  angle_t          e_shaft;
  logic [N2_W-1:0] e_num;

  always_ff @(posedge clk) begin
    if (rst) begin
      e_vld <= 1'b0;
    end else if (en) begin
      e_vld <= d_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e_shaft <= d_shaft;
      e_num   <= {1'b0, d_prod, 1'b0} + {{(N2_W-ANGLE_W){1'b0}}, travel_centideg};
    end
  end

  // ---------------------------------------------------------------------------
  // pulse division by 2 * travel; pos <= travel keeps the quotient within span,
  // so 16 quotient bits are enough
  // ---------------------------------------------------------------------------
  logic   d2_vld;
  pulse_t d2_quo;
  angle_t d2_shaft;

  dasp_div #(
    .NUM_W  (N2_W),
    .DEN_W  (ANGLE_W + 1),
    .QUO_W  (PULSE_W),
    .SIDE_W (ANGLE_W)
  ) u_pulse_div (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_vld   (e_vld),
    .num      (e_num),
    .den      ({travel_centideg, 1'b0}),
    .side_in  (e_shaft),
    .out_vld  (d2_vld),
    .quo      (d2_quo),
    .side_out (d2_shaft)
  );

  // ---------------------------------------------------------------------------
  // output register: offset by min, clamp to max, zero on bad calibration
  // ---------------------------------------------------------------------------
  logic [PULSE_W:0] pulse_sum;
  pulse_t           pulse_clamped;

  assign pulse_sum     = {1'b0, min_pulse_us} + {1'b0, d2_quo};
  assign pulse_clamped = (pulse_sum > {1'b0, max_pulse_us}) ? max_pulse_us :
                         pulse_sum[PULSE_W-1:0];

  pulse_t out_pulse;
  angle_t out_shaft;
  logic   out_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (en) begin
      out_vld <= d2_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_pulse <= cal_ok ? pulse_clamped : '0;
      out_shaft <= cal_ok ? d2_shaft : '0;
      out_ok    <= cal_ok;
    end
  end

  assign pulse.valid          = out_vld;
  assign pulse.pulse_us       = out_pulse;
  assign pulse.shaft_centideg = out_shaft;
  assign pulse.calibration_ok = out_ok;

endmodule

>>> tb/dial_angle_to_servo_pulse_tb.sv
// self-checking bench for dial_angle_to_servo_pulse: register port setup, random dial angles,
// bit-exact pulse and shaft prediction, and in-order checking of every result transaction
// depends on dasp_pkg, dasp_if and the dial_angle_to_servo_pulse rtl
module dial_angle_to_servo_pulse_tb;
  import dasp_pkg::*;

  localparam int GEAR_FRAC   = 8;
  localparam int DRAIN_WAIT  = GEAR_FRAC + 60;  // pipe depth is GEAR_FRAC + 41
  localparam int CYCLE_LIMIT = 400000;
  localparam int RAND_PHASES = 17;
  localparam int PHASE_ITEMS = 50;
  localparam int REPORT_CAP  = 40;

  // register slots past the last register, writes there must change nothing
  localparam logic [REG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  typedef struct packed {
    dial_t dial;
    logic  unusable;
  } dial_item_t;

  typedef struct packed {
    pulse_t pulse;
    angle_t shaft;
    logic   ok;
  } servo_result_t;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  dasp_in_if  dial_ch ();
  dasp_out_if pulse_ch ();

  dial_angle_to_servo_pulse #(.GEAR_FRAC_BITS(GEAR_FRAC)) uut (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .dial    (dial_ch),
    .pulse   (pulse_ch)
  );

  always #1 clk = ~clk;

  // shadow of the calibration registers, updated at the register write edge
  pulse_t                 min_us;
  pulse_t                 max_us;
  angle_t                 travel_cd;
  logic [15:0]            gear_q;
  trim_t                  trim_cd;
  logic                   mirror;

  dial_item_t             dial_backlog[$];    // angles waiting for the driver
  servo_result_t          pulse_expected[$];  // predicted results, oldest first
  int                     mismatch_count = 0;
  int                     cycle_count = 0;
  int                     in_gap = 0;
  int                     out_stall = 0;
  logic                   idling_on;

  // pulse and shaft angle for one dial angle under the current calibration
  function automatic servo_result_t servo_pulse_for(dial_t dial_v, logic unusable);
    servo_result_t r;
    longint        t, g, shaft, num, den, q, pos, span, p;
    r = '0;
    // bad calibration: everything reads zero
    if (max_us <= min_us || travel_cd == 0 || gear_q == 0)
      return r;
    t = longint'(travel_cd);
    if (unusable) begin
      // unusable angle: trim alone sets the shaft
      shaft = longint'(trim_cd);
    end else begin
      // dial / gear rounded half up, as floor((2 * dial * 2^F + gear) / (2 * gear))
      g     = longint'(gear_q);
      num   = longint'(dial_v) * (longint'(1) << (GEAR_FRAC + 1)) + g;
      den   = 2 * g;
      q     = num / den;
      if (num % den != 0 && num < 0)
        q = q - 1;
      shaft = longint'(trim_cd) + q;
    end
    if (shaft < 0)
      shaft = 0;
    if (shaft > t)
      shaft = t;
    // mirroring only moves the pulse, the reported shaft stays unmirrored
    pos  = mirror ? t - shaft : shaft;
    span = longint'(max_us) - longint'(min_us);
    p    = longint'(min_us) + (2 * pos * span + t) / (2 * t);
    if (p > longint'(max_us))
      p = longint'(max_us);
    r.pulse = pulse_t'(p);
    r.shaft = angle_t'(shaft);
    r.ok    = 1'b1;
    return r;
  endfunction

  // setup cycle, then access cycle; the register takes the value when pready is seen
  task automatic reg_write(input logic [REG_IDX_W-1:0] idx, input logic [31:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready)
      @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_MIN_PULSE: min_us    = value[15:0];
      REG_MAX_PULSE: max_us    = value[15:0];
      REG_TRAVEL:    travel_cd = value[15:0];
      REG_GEAR:      gear_q    = value[15:0];
      REG_TRIM:      trim_cd   = value[16:0];
      REG_REVERSED:  mirror    = value[0];
      default: ;
    endcase
  endtask

  task automatic load_settings(input int mn, input int mx, input int trv, input int gr,
                               input int trm, input bit rv);
    reg_write(REG_MIN_PULSE, 32'(mn));
    reg_write(REG_MAX_PULSE, 32'(mx));
    reg_write(REG_TRAVEL, 32'(trv));
    reg_write(REG_GEAR, 32'(gr));
    reg_write(REG_TRIM, 32'(trm));
    reg_write(REG_REVERSED, 32'(rv));
  endtask

  task automatic queue_dial(input int angle, input bit unusable);
    dial_item_t it;
    it.dial     = dial_t'(angle);
    it.unusable = unusable;
    dial_backlog.push_back(it);
  endtask

  // idle means nothing queued, nothing offered and nothing still in the pipe;
  // checked on the falling edge, once the rising edge updates have settled
  task automatic wait_drained();
    while (dial_backlog.size() != 0 || dial_ch.valid || pulse_expected.size() != 0)
      @(negedge clk);
  endtask

  // input driver: predicts each accepted transaction, then offers the next angle
  always @(posedge clk) begin : drive
    dial_item_t next_item;
    if (rst) begin
      dial_ch.valid <= 1'b0;
      in_gap = 0;
    end else begin
      if (dial_ch.valid && dial_ch.ready)
        pulse_expected.push_back(servo_pulse_for(dial_ch.dial_centideg,
                                                 dial_ch.angle_unusable));
      if (!dial_ch.valid || dial_ch.ready) begin
        if (in_gap > 0) begin
          in_gap--;
          dial_ch.valid <= 1'b0;
        end else if (idling_on && $urandom_range(0, 7) == 0) begin
          // start a burst of idle cycles, this one included; in_gap counts the rest
          in_gap = $urandom_range(0, 14);
          dial_ch.valid <= 1'b0;
        end else if (dial_backlog.size() != 0) begin
          next_item = dial_backlog.pop_front();
          dial_ch.valid          <= 1'b1;
          dial_ch.dial_centideg  <= next_item.dial;
          dial_ch.angle_unusable <= next_item.unusable;
        end else begin
          dial_ch.valid <= 1'b0;
        end
      end
    end
  end

  // output monitor: checks each result transaction against the oldest prediction
  always @(posedge clk) begin : watch
    servo_result_t want;
    if (!rst && pulse_ch.valid && pulse_ch.ready) begin
      if (pulse_expected.size() == 0) begin
        if (mismatch_count < REPORT_CAP)
          $display("%0t: result with none expected: pulse %0d shaft %0d ok %0b", $time,
                   pulse_ch.pulse_us, pulse_ch.shaft_centideg, pulse_ch.calibration_ok);
        mismatch_count++;
      end else begin
        want = pulse_expected.pop_front();
        if (pulse_ch.pulse_us !== want.pulse) begin
          if (mismatch_count < REPORT_CAP)
            $display("%0t: pulse_us expected %0d actual %0d", $time, want.pulse,
                     pulse_ch.pulse_us);
          mismatch_count++;
        end
        if (pulse_ch.shaft_centideg !== want.shaft) begin
          if (mismatch_count < REPORT_CAP)
            $display("%0t: shaft_centideg expected %0d actual %0d", $time, want.shaft,
                     pulse_ch.shaft_centideg);
          mismatch_count++;
        end
        if (pulse_ch.calibration_ok !== want.ok) begin
          if (mismatch_count < REPORT_CAP)
            $display("%0t: calibration_ok expected %0b actual %0b", $time, want.ok,
                     pulse_ch.calibration_ok);
          mismatch_count++;
        end
      end
    end
    // receiver stalls in bursts, out_stall counting the stalled cycles still to come
    if (out_stall > 0) begin
      out_stall--;
      pulse_ch.ready <= 1'b0;
    end else if (idling_on && $urandom_range(0, 7) == 0) begin
      out_stall = $urandom_range(0, 14);
      pulse_ch.ready <= 1'b0;
    end else begin
      pulse_ch.ready <= 1'b1;
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("dial_angle_to_servo_pulse: mismatch");
      $finish;
    end
  end

  initial begin : stimulus
    int mn, mx, trv, gr, trm, angle, pick;
    bit rv;
    // every input known from time zero
    rst                    = 1'b1;
    psel                   = 1'b0;
    penable                = 1'b0;
    pwrite                 = 1'b0;
    paddr                  = '0;
    pwdata                 = '0;
    dial_ch.valid          = 1'b0;
    dial_ch.dial_centideg  = '0;
    dial_ch.angle_unusable = 1'b0;
    pulse_ch.ready         = 1'b0;
    idling_on              = 1'b1;
    min_us                 = RST_MIN_PULSE;
    max_us                 = RST_MAX_PULSE;
    travel_cd              = RST_TRAVEL;
    gear_q                 = RST_GEAR;
    trim_cd                = '0;
    mirror                 = 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // reset calibration: unity gear, zero trim, 1000..2000 us over 180 degrees
    queue_dial(0, 0);
    queue_dial(9000, 0);
    queue_dial(18000, 0);
    queue_dial(36000, 0);        // beyond travel, clamps high
    queue_dial(-36000, 0);       // negative, clamps to zero
    queue_dial(1, 0);
    queue_dial(-1, 0);
    queue_dial(65535, 0);        // field extremes
    queue_dial(-65536, 0);
    queue_dial(12345, 1);        // unusable angle, trim only
    queue_dial(-65536, 1);
    wait_drained();

    // gear of two, so odd dials land exactly on half a centidegree; full-scale pulse,
    // travel above nominal, mirrored
    load_settings(0, 65535, 65535, 512, 100, 1);
    queue_dial(1, 0);
    queue_dial(-1, 0);
    queue_dial(3, 0);
    queue_dial(-201, 0);
    queue_dial(0, 1);
    wait_drained();

    // each kind of bad calibration: max equal to min, max below min, no travel, no gear
    load_settings(1500, 1500, 18000, 256, 0, 0);
    queue_dial(5000, 0);
    wait_drained();
    reg_write(REG_MAX_PULSE, 32'd900);
    queue_dial(5000, 0);
    wait_drained();
    load_settings(1000, 2000, 0, 256, 0, 0);
    queue_dial(5000, 1);
    wait_drained();
    load_settings(1000, 2000, 18000, 0, 0, 0);
    queue_dial(5000, 0);
    wait_drained();

    // writes past the last register must leave the calibration alone
    load_settings(1000, 2000, 18000, 1, -36000, 0);
    reg_write(REG_SPARE_LO, 32'hFFFF_FFFF);
    reg_write(REG_SPARE_HI, 32'h0000_0000);
    queue_dial(100, 0);
    queue_dial(-100, 1);
    wait_drained();

    // random part: a fresh calibration per phase, mostly valid, with extremes mixed in
    for (int k = 0; k < RAND_PHASES; k++) begin
      case (k)
        0: load_settings(0, 65535, 65535, 65535, 65535, 0);
        1: load_settings(0, 1, 1, 1, -65536, 1);
        2: load_settings(65534, 65535, 36000, 256, 36000, 1);
        default: begin
          mn  = $urandom_range(0, 2000);
          mx  = mn + $urandom_range(1, 3000);
          trv = $urandom_range(1000, 36000);
          gr  = $urandom_range(32, 2048);
          trm = int'($urandom_range(0, 8000)) - 4000;
          rv  = $urandom_range(0, 1);
          if ($urandom_range(0, 4) == 0)
            trv = $urandom_range(36001, 65535);
          if ($urandom_range(0, 4) == 0)
            gr = $urandom_range(0, 1) ? $urandom_range(1, 31) : $urandom_range(2049, 65535);
          if ($urandom_range(0, 5) == 0)
            trm = int'($urandom_range(0, 131071)) - 65536;
          if ($urandom_range(0, 7) == 0) begin
            case ($urandom_range(0, 2))
              0: mx = $urandom_range(0, mn);
              1: trv = 0;
              default: gr = 0;
            endcase
          end
          load_settings(mn, mx, trv, gr, trm, rv);
        end
      endcase
      // the last phases run flat out; elsewhere idling is on most of the time
      idling_on <= (k < RAND_PHASES - 2) && ($urandom_range(0, 3) != 0);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        pick = $urandom_range(0, 7);
        if (pick == 0)
          angle = int'($urandom_range(0, 131071)) - 65536;
        else if (pick == 1)
          angle = int'($urandom_range(0, 600)) - 300;
        else
          angle = int'($urandom_range(0, 72000)) - 36000;
        queue_dial(angle, $urandom_range(0, 7) == 0);
      end
      wait_drained();
    end

    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatch_count == 0)
      $display("dial_angle_to_servo_pulse: match");
    else
      $display("dial_angle_to_servo_pulse: mismatch");
    $finish;
  end

endmodule
